@@ hw/rtl/fla_pkg.sv @@
`default_nettype none
package fla_pkg;

    // Fixed geometry of the pool and of the fields.
    localparam int MAX_EXTENTS_DEF = 64;
    localparam int POOL_LIMIT      = 65536;
    localparam int POOL_MIN        = 64;
    localparam int ALIGN_BYTES     = 16;
    localparam int ALIGN_LOG2      = $clog2(ALIGN_BYTES);
    localparam int HEADER_BYTES    = 16;
    localparam int MIN_REQUEST     = 16;
    localparam int SIZE_W          = 17;
    localparam int ADDR_W          = 16;
    localparam int PAD_W           = $clog2(HEADER_BYTES + ALIGN_BYTES);
    localparam int REC_DEPTH       = POOL_LIMIT / ALIGN_BYTES;
    localparam int REC_IW          = $clog2(REC_DEPTH);
    localparam int REC_W           = SIZE_W + PAD_W;

    // Operations.
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_FREE_ALL = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_SMALL = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_POOL   = 2'd1;

    // Datapath commands.
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE    = 4'd0;
    localparam t_cmd CMD_LOAD    = 4'd1;
    localparam t_cmd CMD_WHOLE   = 4'd2;
    localparam t_cmd CMD_ASCAN   = 4'd3;
    localparam t_cmd CMD_ACOMMIT = 4'd4;
    localparam t_cmd CMD_SHDN    = 4'd5;
    localparam t_cmd CMD_FCHK    = 4'd6;
    localparam t_cmd CMD_FSCAN   = 4'd7;
    localparam t_cmd CMD_FDEC    = 4'd8;
    localparam t_cmd CMD_SHUP    = 4'd9;
    localparam t_cmd CMD_EMIT    = 4'd10;

    // One free extent.
    typedef struct packed {
        logic [SIZE_W-1:0] len;
        logic [ADDR_W-1:0] start;
    } t_ext;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic ascan_last;
        logic a_shift;
        logic f_bad;
        logic fscan_stop;
        logic dec_shdn;
        logic dec_shup;
        logic shdn_done;
        logic shup_done;
        logic slot_free;
    } t_sts;

    // Padding from an extent start to an aligned user offset with header room.
    function automatic logic [PAD_W-1:0] pad_for(input logic [ALIGN_LOG2-1:0] rem);
        int p;
        p = (rem == '0) ? 0 : ALIGN_BYTES - int'(rem);
        if (p < HEADER_BYTES) begin
            p = p + ALIGN_BYTES * ((HEADER_BYTES - p + ALIGN_BYTES - 1) / ALIGN_BYTES);
        end
        return PAD_W'(p);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fla_ctrl.sv @@
`default_nettype none
module fla_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire [1:0]       i_op,
    input  wire fla_pkg::t_sts i_sts,
    output logic            o_in_stall,
    output fla_pkg::t_cmd   o_cmd
);
    import fla_pkg::*;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ASCAN   = 4'd2;
    localparam logic [3:0] S_ACOMMIT = 4'd3;
    localparam logic [3:0] S_SHDN    = 4'd4;
    localparam logic [3:0] S_FCHK    = 4'd5;
    localparam logic [3:0] S_FSCAN   = 4'd6;
    localparam logic [3:0] S_FDEC    = 4'd7;
    localparam logic [3:0] S_SHUP    = 4'd8;
    localparam logic [3:0] S_WHOLE   = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_INIT: begin
                o_cmd   = CMD_WHOLE;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = CMD_LOAD;
                    case (i_op)
                        OP_ALLOC:    n_state = S_ASCAN;
                        OP_FREE:     n_state = S_FCHK;
                        OP_FREE_ALL: n_state = S_WHOLE;
                        default:     n_state = S_EMIT;
                    endcase
                end
            end
            S_ASCAN: begin
                o_cmd = CMD_ASCAN;
                if (i_sts.ascan_last) n_state = S_ACOMMIT;
            end
            S_ACOMMIT: begin
                o_cmd   = CMD_ACOMMIT;
                n_state = i_sts.a_shift ? S_SHDN : S_EMIT;
            end
            S_SHDN: begin
                o_cmd = CMD_SHDN;
                if (i_sts.shdn_done) n_state = S_EMIT;
            end
            S_FCHK: begin
                o_cmd   = CMD_FCHK;
                n_state = i_sts.f_bad ? S_EMIT : S_FSCAN;
            end
            S_FSCAN: begin
                o_cmd = CMD_FSCAN;
                if (i_sts.fscan_stop) n_state = S_FDEC;
            end
            S_FDEC: begin
                o_cmd = CMD_FDEC;
                if (i_sts.dec_shdn) begin
                    n_state = S_SHDN;
                end else if (i_sts.dec_shup) begin
                    n_state = S_SHUP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SHUP: begin
                o_cmd = CMD_SHUP;
                if (i_sts.shup_done) n_state = S_EMIT;
            end
            S_WHOLE: begin
                o_cmd   = CMD_WHOLE;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/fla_dp.sv @@
`default_nettype none
module fla_dp #(
    parameter int MAX_EXTENTS = fla_pkg::MAX_EXTENTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire fla_pkg::t_cmd           i_cmd,
    output fla_pkg::t_sts                o_sts,
    input  wire                          i_cfg_we,
    input  wire [1:0]                    i_cfg_index,
    input  wire [fla_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire [fla_pkg::SIZE_W-1:0]    i_req_size,
    input  wire [fla_pkg::ADDR_W-1:0]    i_block_addr,
    input  wire                          i_out_stall,
    output logic                         o_out_valid,
    output logic [fla_pkg::ADDR_W-1:0]   o_user_addr,
    output logic [1:0]                   o_status,
    output logic [fla_pkg::SIZE_W-1:0]   o_used_bytes,
    output logic [fla_pkg::SIZE_W-1:0]   o_peak_bytes
);
    import fla_pkg::*;

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

    // Extent table and header records.
    t_ext              ext_mem [MAX_EXTENTS];
    logic [REC_W-1:0]  rec_mem [REC_DEPTH];

    logic              ext_we;
    logic [IW-1:0]     ext_waddr;
    t_ext              ext_wdata;
    logic              ext_re;
    logic [IW-1:0]     ext_raddr;
    logic              rec_we;
    logic [REC_IW-1:0] rec_waddr;
    logic [REC_W-1:0]  rec_wdata;

    logic              r_policy;
    logic [SIZE_W-1:0] r_pool;
    logic [SIZE_W-1:0] r_size,   n_size;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic [CW-1:0]     r_cnt,    n_cnt;
    logic [CW-1:0]     r_ridx,   n_ridx;
    logic [CW-1:0]     r_widx,   n_widx;
    logic [CW-1:0]     r_pos,    n_pos;
    t_ext              r_rd;
    logic [REC_W-1:0]  r_rec;
    logic              r_found,  n_found;
    logic [CW-1:0]     r_pick,   n_pick;
    logic [PAD_W-1:0]  r_ppad,   n_ppad;
    logic [ADDR_W-1:0] r_pstart, n_pstart;
    logic [SIZE_W-1:0] r_best,   n_best;
    t_ext              r_prev,   n_prev;
    logic              r_hasprev, n_hasprev;
    t_ext              r_next,   n_next;
    logic              r_hasnext, n_hasnext;
    logic [ADDR_W-1:0] r_fstart, n_fstart;
    logic [SIZE_W-1:0] r_flen,   n_flen;
    logic [SIZE_W-1:0] r_used,   n_used;
    logic [SIZE_W-1:0] r_peak,   n_peak;
    logic [ADDR_W-1:0] r_user,   n_user;
    logic [1:0]        r_stat,   n_stat;
    logic              r_ovld;

    // Allocate scan terms.
    logic              a_valid;
    logic [PAD_W-1:0]  a_pad;
    logic [SIZE_W:0]   a_need;
    logic              a_fit;
    logic [SIZE_W-1:0] a_diff;
    logic              a_small;
    logic [SIZE_W:0]   c_need;
    logic [ADDR_W-1:0] c_user;

    // Free check terms.
    logic [SIZE_W-1:0] eff_pool;
    logic [PAD_W-1:0]  f_pad;
    logic [SIZE_W:0]   f_len;
    logic [ADDR_W-1:0] f_start;
    logic [SIZE_W+1:0] f_end;

    // Free scan and merge terms.
    logic              s_valid;
    logic              s_go;
    logic [SIZE_W:0]   d_pend;
    logic [SIZE_W:0]   d_fend;
    logic              d_ovp;
    logic              d_ovn;
    logic              d_mp;
    logic              d_mn;
    logic [SIZE_W+1:0] d_sum;

    assign eff_pool = (r_pool > SIZE_W'(POOL_LIMIT)) ? SIZE_W'(POOL_LIMIT) :
                      (r_pool < SIZE_W'(POOL_MIN))   ? SIZE_W'(POOL_MIN)   : r_pool;

    assign a_valid = (r_ridx < r_cnt);
    assign a_pad   = pad_for(r_rd.start[ALIGN_LOG2-1:0]);
    assign a_need  = {1'b0, r_size} + (SIZE_W+1)'(a_pad);
    assign a_fit   = a_valid && ({1'b0, r_rd.len} >= a_need);
    assign a_diff  = SIZE_W'({1'b0, r_rd.len} - a_need);
    assign a_small = (r_size < SIZE_W'(MIN_REQUEST));
    assign c_need  = {1'b0, r_size} + (SIZE_W+1)'(r_ppad);
    assign c_user  = r_pstart + ADDR_W'(r_ppad);

    assign f_pad   = r_rec[PAD_W-1:0];
    assign f_len   = {1'b0, r_rec[REC_W-1:PAD_W]} + (SIZE_W+1)'(f_pad);
    assign f_start = r_addr - ADDR_W'(f_pad);
    assign f_end   = (SIZE_W+2)'(f_start) + {1'b0, f_len};

    assign s_valid = (r_ridx < r_cnt);
    assign s_go    = s_valid && (r_rd.start <= r_fstart);

    assign d_pend  = (SIZE_W+1)'(r_prev.start) + (SIZE_W+1)'(r_prev.len);
    assign d_fend  = (SIZE_W+1)'(r_fstart) + (SIZE_W+1)'(r_flen);
    assign d_ovp   = r_hasprev && (d_pend > (SIZE_W+1)'(r_fstart));
    assign d_ovn   = r_hasnext && (d_fend > (SIZE_W+1)'(r_next.start));
    assign d_mp    = r_hasprev && (d_pend == (SIZE_W+1)'(r_fstart));
    assign d_mn    = r_hasnext && (d_fend == (SIZE_W+1)'(r_next.start));
    assign d_sum   = (SIZE_W+2)'(r_prev.len) + (SIZE_W+2)'(r_flen) + (SIZE_W+2)'(r_next.len);

    always_comb begin
        o_sts.ascan_last = !a_valid || (({1'b0, r_ridx} + 1'b1) >= {1'b0, r_cnt}) ||
                           (!r_policy && (r_found || a_fit));
        o_sts.a_shift    = r_found && !a_small && (r_best == '0);
        o_sts.f_bad      = (r_addr[ALIGN_LOG2-1:0] != '0) ||
                           (f_pad < PAD_W'(HEADER_BYTES)) ||
                           (ADDR_W'(f_pad) > r_addr) ||
                           (f_end > (SIZE_W+2)'(eff_pool)) ||
                           (f_len > {1'b0, r_used});
        o_sts.fscan_stop = !s_go;
        o_sts.dec_shdn   = !d_ovp && !d_ovn && d_mp && d_mn;
        o_sts.dec_shup   = !d_ovp && !d_ovn && !d_mp && !d_mn &&
                           (r_cnt < CW'(MAX_EXTENTS));
        o_sts.shdn_done  = (({1'b0, r_widx} + 1'b1) >= {1'b0, r_cnt});
        o_sts.shup_done  = (r_widx <= r_pos);
        o_sts.slot_free  = !r_ovld || !i_out_stall;
    end

    always_comb begin
        n_size    = r_size;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_ridx    = r_ridx;
        n_widx    = r_widx;
        n_pos     = r_pos;
        n_found   = r_found;
        n_pick    = r_pick;
        n_ppad    = r_ppad;
        n_pstart  = r_pstart;
        n_best    = r_best;
        n_prev    = r_prev;
        n_hasprev = r_hasprev;
        n_next    = r_next;
        n_hasnext = r_hasnext;
        n_fstart  = r_fstart;
        n_flen    = r_flen;
        n_used    = r_used;
        n_peak    = r_peak;
        n_user    = r_user;
        n_stat    = r_stat;
        ext_we    = 1'b0;
        ext_waddr = '0;
        ext_wdata = r_rd;
        ext_re    = 1'b0;
        ext_raddr = '0;
        rec_we    = 1'b0;
        rec_waddr = c_user[ALIGN_LOG2 +: REC_IW];
        rec_wdata = {r_size, r_ppad};
        case (i_cmd)
            CMD_LOAD: begin
                n_size    = i_req_size;
                n_addr    = i_block_addr;
                n_user    = '0;
                n_stat    = ST_OK;
                n_found   = 1'b0;
                n_hasprev = 1'b0;
                n_hasnext = 1'b0;
                n_ridx    = '0;
                ext_re    = 1'b1;
            end
            CMD_WHOLE: begin
                ext_we    = 1'b1;
                ext_wdata = '{len: eff_pool, start: '0};
                n_cnt     = CW'(1);
                n_used    = '0;
                n_peak    = '0;
            end
            CMD_ASCAN: begin
                if (a_fit && (!r_found || (a_diff < r_best))) begin
                    n_found  = 1'b1;
                    n_pick   = r_ridx;
                    n_ppad   = a_pad;
                    n_pstart = r_rd.start;
                    n_best   = a_diff;
                end
                n_ridx    = r_ridx + 1'b1;
                ext_re    = 1'b1;
                ext_raddr = IW'(r_ridx + 1'b1);
            end
            CMD_ACOMMIT: begin
                if (a_small) begin
                    n_stat = ST_SMALL;
                end else if (!r_found) begin
                    n_stat = ST_NOFIT;
                end else begin
                    n_user = c_user;
                    n_used = r_used + SIZE_W'(c_need);
                    if ((r_used + SIZE_W'(c_need)) > r_peak) begin
                        n_peak = r_used + SIZE_W'(c_need);
                    end
                    rec_we = 1'b1;
                    if (r_best != '0) begin
                        ext_we    = 1'b1;
                        ext_waddr = IW'(r_pick);
                        ext_wdata = '{len: r_best, start: r_pstart + ADDR_W'(c_need)};
                    end else begin
                        n_widx    = r_pick;
                        ext_re    = 1'b1;
                        ext_raddr = IW'(r_pick + 1'b1);
                    end
                end
            end
            CMD_SHDN: begin
                if (({1'b0, r_widx} + 1'b1) < {1'b0, r_cnt}) begin
                    ext_we    = 1'b1;
                    ext_waddr = IW'(r_widx);
                    ext_wdata = r_rd;
                    n_widx    = r_widx + 1'b1;
                    ext_re    = 1'b1;
                    ext_raddr = IW'(r_widx + CW'(2));
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            CMD_FCHK: begin
                n_fstart = f_start;
                n_flen   = SIZE_W'(f_len);
                if (o_sts.f_bad) n_stat = ST_NOFIT;
            end
            CMD_FSCAN: begin
                if (s_go) begin
                    n_prev    = r_rd;
                    n_hasprev = 1'b1;
                    n_ridx    = r_ridx + 1'b1;
                    ext_re    = 1'b1;
                    ext_raddr = IW'(r_ridx + 1'b1);
                end else begin
                    n_pos     = r_ridx;
                    n_hasnext = s_valid;
                    n_next    = r_rd;
                end
            end
            CMD_FDEC: begin
                if (d_ovp || d_ovn) begin
                    n_stat = ST_NOFIT;
                end else if (d_mp && d_mn) begin
                    ext_we    = 1'b1;
                    ext_waddr = IW'(r_pos - 1'b1);
                    ext_wdata = '{len: SIZE_W'(d_sum), start: r_prev.start};
                    n_used    = r_used - r_flen;
                    n_widx    = r_pos;
                    ext_re    = 1'b1;
                    ext_raddr = IW'(r_pos + 1'b1);
                end else if (d_mp) begin
                    ext_we    = 1'b1;
                    ext_waddr = IW'(r_pos - 1'b1);
                    ext_wdata = '{len: r_prev.len + r_flen, start: r_prev.start};
                    n_used    = r_used - r_flen;
                end else if (d_mn) begin
                    ext_we    = 1'b1;
                    ext_waddr = IW'(r_pos);
                    ext_wdata = '{len: r_next.len + r_flen, start: r_fstart};
                    n_used    = r_used - r_flen;
                end else if (r_cnt >= CW'(MAX_EXTENTS)) begin
                    n_stat = ST_FULL;
                end else begin
                    n_used    = r_used - r_flen;
                    n_widx    = r_cnt;
                    ext_re    = 1'b1;
                    ext_raddr = IW'(r_cnt - 1'b1);
                end
            end
            CMD_SHUP: begin
                if (r_widx > r_pos) begin
                    ext_we    = 1'b1;
                    ext_waddr = IW'(r_widx);
                    ext_wdata = r_rd;
                    n_widx    = r_widx - 1'b1;
                    ext_re    = 1'b1;
                    ext_raddr = IW'(r_widx - CW'(2));
                end else begin
                    ext_we    = 1'b1;
                    ext_waddr = IW'(r_pos);
                    ext_wdata = '{len: r_flen, start: r_fstart};
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (ext_we) ext_mem[ext_waddr] <= ext_wdata;
        if (ext_re) r_rd <= ext_mem[ext_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[rec_waddr] <= rec_wdata;
        if (i_cmd == CMD_LOAD) r_rec <= rec_mem[i_block_addr[ALIGN_LOG2 +: REC_IW]];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_addr    <= n_addr;
        r_ridx    <= n_ridx;
        r_widx    <= n_widx;
        r_pos     <= n_pos;
        r_pick    <= n_pick;
        r_ppad    <= n_ppad;
        r_pstart  <= n_pstart;
        r_best    <= n_best;
        r_prev    <= n_prev;
        r_next    <= n_next;
        r_fstart  <= n_fstart;
        r_flen    <= n_flen;
        r_user    <= n_user;
        r_stat    <= n_stat;
        r_found   <= n_found;
        r_hasprev <= n_hasprev;
        r_hasnext <= n_hasnext;
        if (i_cmd == CMD_EMIT) begin
            o_user_addr  <= (r_stat == ST_OK) ? r_user : '0;
            o_status     <= r_stat;
            o_used_bytes <= r_used;
            o_peak_bytes <= r_peak;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_pool   <= SIZE_W'(POOL_LIMIT);
            r_cnt    <= '0;
            r_used   <= '0;
            r_peak   <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_POLICY)) r_policy <= i_cfg_data[0];
            if (i_cfg_we && (i_cfg_index == REG_POOL))   r_pool   <= i_cfg_data;
            r_cnt  <= n_cnt;
            r_used <= n_used;
            r_peak <= n_peak;
            if (i_cmd == CMD_EMIT) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovld;

endmodule
`default_nettype wire

@@ hw/rtl/free_list_block_allocator.sv @@
`default_nettype none
// Free-list allocator over a byte pool. Free space is held as an address-sorted
// table of extents in a memory with one read and one write port, and allocation
// headers (size and padding) live in a record memory indexed by user offset over
// sixteen. Each beat on the input channel carries one request (allocate, free or
// free all) and gives exactly one result beat with the user offset, a status and
// the used and peak byte counts. Requests are handled one at a time. An allocate
// scans the table one entry at a time (first fit can end the scan sooner), and an
// exact fit that removes an entry then moves the table below it up. A free scans
// the extents below the freed block, then shifts the table when an entry is
// inserted or two extents merge. The table shift, one entry per cycle through the
// memory port, sets the worst case. A stalled result beat holds back the next
// result until it leaves. After reset the block seeds the table with the whole
// pool before it takes its first beat. Configuration writes are always taken; the
// pool size bounds free checks at once and fills the table at reset and at the
// next free all, and the placement policy is used at once.
module free_list_block_allocator #(
    parameter int MAX_EXTENTS = fla_pkg::MAX_EXTENTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [1:0]                    i_op,
    input  wire [fla_pkg::SIZE_W-1:0]    i_req_size,
    input  wire [fla_pkg::ADDR_W-1:0]    i_block_addr,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [fla_pkg::ADDR_W-1:0]   o_user_addr,
    output logic [1:0]                   o_status,
    output logic [fla_pkg::SIZE_W-1:0]   o_used_bytes,
    output logic [fla_pkg::SIZE_W-1:0]   o_peak_bytes,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [1:0]                    i_cfg_index,
    input  wire [fla_pkg::SIZE_W-1:0]    i_cfg_data
);
    import fla_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The configuration registers accept a write in any cycle.
    assign o_cfg_ready = 1'b1;

    fla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fla_dp #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_size   (i_req_size),
        .i_block_addr (i_block_addr),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_user_addr  (o_user_addr),
        .o_status     (o_status),
        .o_used_bytes (o_used_bytes),
        .o_peak_bytes (o_peak_bytes)
    );

endmodule
`default_nettype wire
